/* rtl/bpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants of the button press / hold event generator.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int LEVEL_W  = 8;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // buttons at or beyond this index have no level bit
  localparam int LEVEL_BITS = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT   = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd100;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    EV_PRESS     = 3'd0,
    EV_CLICK     = 3'd1,
    EV_RELEASE   = 3'd2,
    EV_HOLD_ONCE = 3'd3,
    EV_HOLD      = 3'd4
  } ev_kind_t;

  // per-button state entry
  typedef struct packed {
    logic              pressed;
    logic              hold_sent;
    logic [TIME_W-1:0] press_start;
    logic [TIME_W-1:0] last_edge;
    logic [TIME_W-1:0] last_repeat;
  } bpe_entry_t;

endpackage

/* rtl/bpe_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_in_if
// Tick channel: millisecond time and active-low button levels.
// ----------------------------------------------------------------------------
interface bpe_in_if import bpe_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  now_ms;
  logic [LEVEL_W-1:0] low_levels;

  modport source (output valid, output now_ms, output low_levels, input ready);
  modport sink   (input valid, input now_ms, input low_levels, output ready);

endinterface

/* rtl/bpe_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_out_if
// Event channel: event kind, button slot and end-of-tick marker.
// ----------------------------------------------------------------------------
interface bpe_out_if import bpe_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [SLOT_W-1:0] button_slot;
  logic              last_event;

  modport source (output valid, output event_kind, output button_slot,
                  output last_event, input ready);
  modport sink   (input valid, input event_kind, input button_slot,
                  input last_event, output ready);

endinterface

/* rtl/bpe_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpe_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bpe_cfg_if import bpe_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

/* rtl/button_press_hold_event_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_hold_event_generator
// Debounced press, click, release, hold and auto-repeat events per button.
// ----------------------------------------------------------------------------
// Each tick request carries the millisecond time and one active-low level bit
// per button. The block walks the buttons in index order through a per-button
// state memory with a registered read: each button passes a read state and an
// update state, each event an emit state on its way toward the output, and
// the tick an idle state that accepts it and a flush state that marks its
// final event. The walk waits while the output side stalls, and the next tick
// is taken once the current one is fully walked. Events leave one at a time;
// last_event marks the final event of a tick and a quiet tick emits nothing.
// Time differences wrap modulo 2^32. The user must write configuration only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module button_press_hold_event_generator
  import bpe_pkg::*;
#(
  parameter int BUTTON_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  bpe_in_if.sink          in_chan,
  bpe_out_if.source       out_chan,
  bpe_cfg_if.sink         cfg_chan
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUTTON_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  state_t state_r;

  // configuration registers
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] hold_r;
  logic [CFG_W-1:0] repeat_r;

  // latched tick
  logic [TIME_W-1:0]  now_r;
  logic [LEVEL_W-1:0] levels_r;
  logic [IDX_W-1:0]   idx_r;

  // state memory and its read port
  bpe_entry_t              state_mem [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] vld_r;
  bpe_entry_t              rd_data_r;
  logic                    rd_vld_r;

  // events of the current button
  ev_kind_t ev0_r, ev1_r;
  logic     ev_two_r;
  logic     ev_sel_r;

  // one event held back until we know whether it ends the tick
  ev_kind_t          pend_kind_r;
  logic [SLOT_W-1:0] pend_slot_r;
  logic              pend_vld_r;

  // output register
  logic              out_valid_r;
  ev_kind_t          out_kind_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_last_r;

  // combinational update of one button
  bpe_entry_t        cur;
  bpe_entry_t        upd;
  logic [31:0]       idx_ext;
  logic [SLOT_W-1:0] slot;
  logic              low;
  logic [TIME_W-1:0] d_edge, d_press, d_rep;
  ev_kind_t          nx_ev0, nx_ev1;
  logic [1:0]        nx_cnt;
  ev_kind_t          cur_ev;
  logic              out_free;
  logic              out_load;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.event_kind  = out_kind_r;
  assign out_chan.button_slot = out_slot_r;
  assign out_chan.last_event  = out_last_r;

  assign out_free = !out_valid_r || out_chan.ready;
  assign cur_ev   = ev_sel_r ? ev1_r : ev0_r;

  // held event moves into the output register
  assign out_load = pend_vld_r && out_free &&
                    ((state_r == ST_EMIT) || (state_r == ST_FLUSH));

  // per-button decision, mirrors the press / release / hold / repeat order
  always_comb begin
    cur     = rd_vld_r ? rd_data_r : '0;
    idx_ext = 32'(idx_r);
    slot    = idx_ext[SLOT_W-1:0];
    low     = (idx_ext < 32'(LEVEL_BITS)) && levels_r[idx_ext[2:0]];
    d_edge  = now_r - cur.last_edge;
    d_press = now_r - cur.press_start;
    d_rep   = now_r - cur.last_repeat;
    upd     = cur;
    nx_ev0  = EV_PRESS;
    nx_ev1  = EV_HOLD;
    nx_cnt  = 2'd0;
    if (low && !cur.pressed && (d_edge > {16'd0, debounce_r})) begin
      upd.pressed     = 1'b1;
      upd.hold_sent   = 1'b0;
      upd.press_start = now_r;
      upd.last_edge   = now_r;
      nx_ev0          = EV_PRESS;
      nx_cnt          = 2'd1;
    end else if (!low && cur.pressed) begin
      upd.pressed   = 1'b0;
      upd.hold_sent = 1'b0;
      upd.last_edge = now_r;
      nx_ev0        = cur.hold_sent ? EV_RELEASE : EV_CLICK;
      nx_cnt        = 2'd1;
    end else if (low && cur.pressed && !cur.hold_sent &&
                 (d_press > {16'd0, hold_r})) begin
      upd.hold_sent   = 1'b1;
      upd.last_repeat = now_r;
      nx_ev0          = EV_HOLD_ONCE;
      nx_ev1          = EV_HOLD;
      nx_cnt          = 2'd2;
    end else if (low && cur.pressed && cur.hold_sent &&
                 (d_rep >= {16'd0, repeat_r})) begin
      upd.last_repeat = now_r;
      nx_ev0          = EV_HOLD;
      nx_cnt          = 2'd1;
    end
  end

  // state memory: read every cycle at the walk index, write in update
  always_ff @(posedge clk) begin
    rd_data_r <= state_mem[idx_r];
    rd_vld_r  <= vld_r[idx_r];
    if (state_r == ST_EXEC) begin
      state_mem[idx_r] <= upd;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      hold_r     <= HOLD_RST;
      repeat_r   <= REPEAT_RST;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        CFG_DEBOUNCE: debounce_r <= cfg_chan.data;
        CFG_HOLD:     hold_r     <= cfg_chan.data;
        CFG_REPEAT:   repeat_r   <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      ev_sel_r    <= 1'b0;
    end else begin
      // output loads from the held event, or drains when taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            now_r    <= in_chan.now_ms;
            levels_r <= in_chan.low_levels;
            idx_r    <= '0;
            state_r  <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          vld_r[idx_r] <= 1'b1;
          ev0_r        <= nx_ev0;
          ev1_r        <= nx_ev1;
          ev_two_r     <= (nx_cnt == 2'd2);
          ev_sel_r     <= 1'b0;
          if (nx_cnt != 2'd0) begin
            state_r <= ST_EMIT;
          end else if (idx_r == IDX_LAST) begin
            state_r <= ST_FLUSH;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (!pend_vld_r || out_free) begin
            // the held event is not the last one, send it on
            if (pend_vld_r) begin
              out_kind_r  <= pend_kind_r;
              out_slot_r  <= pend_slot_r;
              out_last_r  <= 1'b0;
            end
            pend_vld_r  <= 1'b1;
            pend_kind_r <= cur_ev;
            pend_slot_r <= slot;
            if (ev_two_r && !ev_sel_r) begin
              ev_sel_r <= 1'b1;
            end else if (idx_r == IDX_LAST) begin
              state_r <= ST_FLUSH;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_vld_r) begin
            state_r <= ST_IDLE;
          end else if (out_free) begin
            out_kind_r  <= pend_kind_r;
            out_slot_r  <= pend_slot_r;
            out_last_r  <= 1'b1;
            pend_vld_r  <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button press / hold event generator: tick
// requests are driven from a queue, each accepted tick is run through a
// local per-button predictor, and every event leaving the block is checked
// field by field against the oldest predicted event.
// ----------------------------------------------------------------------------
module testbench
  import bpe_pkg::*;
();

  localparam int N_BUTTONS     = 8;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 60;
  localparam int CHOKE_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 400000;

  // register index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [CFG_W-1:0]     CFG_MAX   = 16'hFFFF;

  typedef struct {
    logic [TIME_W-1:0]  now_ms;
    logic [LEVEL_W-1:0] low_levels;
  } tick_t;

  typedef struct {
    ev_kind_t          kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } button_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpe_in_if  tick_if ();
  bpe_out_if event_if ();
  bpe_cfg_if cfg_if ();

  button_press_hold_event_generator #(
    .BUTTON_COUNT(N_BUTTONS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (tick_if),
    .out_chan(event_if),
    .cfg_chan(cfg_if)
  );

  always #6 clk = ~clk;

  // pending tick requests and predicted events
  tick_t         pending_ticks[$];
  button_event_t pending_events[$];

  // predictor copy of configuration and per-button state
  logic [CFG_W-1:0]  cfg_debounce;
  logic [CFG_W-1:0]  cfg_hold;
  logic [CFG_W-1:0]  cfg_repeat;
  logic              btn_down [N_BUTTONS];
  logic              btn_held [N_BUTTONS];
  logic [TIME_W-1:0] down_since [N_BUTTONS];
  logic [TIME_W-1:0] edge_at [N_BUTTONS];
  logic [TIME_W-1:0] repeat_at [N_BUTTONS];

  // stimulus generator state
  logic [TIME_W-1:0]  clock_ms;
  logic [LEVEL_W-1:0] levels;

  logic no_idle;
  logic choke_go;
  logic choke_used;
  int   choke_left;
  int   fail_count = 0;
  int   cycle_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // walk the buttons in order and queue the events this tick causes
  task automatic predict_tick(input tick_t t);
    logic              low;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_repeat;
    button_event_t     ev_list[$];
    for (int i = 0; i < N_BUTTONS; i++) begin
      low          = t.low_levels[i];
      since_edge   = t.now_ms - edge_at[i];
      since_press  = t.now_ms - down_since[i];
      since_repeat = t.now_ms - repeat_at[i];
      if (low && !btn_down[i] && since_edge > {16'd0, cfg_debounce}) begin
        btn_down[i]   = 1'b1;
        btn_held[i]   = 1'b0;
        down_since[i] = t.now_ms;
        edge_at[i]    = t.now_ms;
        ev_list.push_back('{kind: EV_PRESS, slot: SLOT_W'(i), last: 1'b0});
      end else if (!low && btn_down[i]) begin
        btn_down[i] = 1'b0;
        edge_at[i]  = t.now_ms;
        ev_list.push_back('{kind: (btn_held[i] ? EV_RELEASE : EV_CLICK),
                            slot: SLOT_W'(i), last: 1'b0});
        btn_held[i] = 1'b0;
      end else if (low && btn_down[i] && !btn_held[i] &&
                   since_press > {16'd0, cfg_hold}) begin
        btn_held[i]  = 1'b1;
        repeat_at[i] = t.now_ms;
        ev_list.push_back('{kind: EV_HOLD_ONCE, slot: SLOT_W'(i), last: 1'b0});
        ev_list.push_back('{kind: EV_HOLD, slot: SLOT_W'(i), last: 1'b0});
      end else if (low && btn_down[i] && btn_held[i]) begin
        if (since_repeat >= {16'd0, cfg_repeat}) begin
          repeat_at[i] = t.now_ms;
          ev_list.push_back('{kind: EV_HOLD, slot: SLOT_W'(i), last: 1'b0});
        end
      end
    end
    if (ev_list.size() != 0)
      ev_list[ev_list.size() - 1].last = 1'b1;
    foreach (ev_list[k])
      pending_events.push_back(ev_list[k]);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_if.valid && tick_if.ready)
        predict_tick(pending_ticks.pop_front());
      // a request not yet taken stays on the channel unchanged
      if (!(tick_if.valid && !tick_if.ready)) begin
        if (pending_ticks.size() != 0 && (no_idle || $urandom_range(0, 99) >= 31)) begin
          tick_if.valid      <= 1'b1;
          tick_if.now_ms     <= pending_ticks[0].now_ms;
          tick_if.low_levels <= pending_ticks[0].low_levels;
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      choke_left <= 0;
      choke_used <= 1'b0;
    end else if (choke_go && !choke_used) begin
      choke_left <= CHOKE_CYCLES;
      choke_used <= 1'b1;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  // event monitor and checker
  always @(posedge clk) begin : event_check
    button_event_t want;
    if (!rst_n) begin
      event_if.ready <= 1'b0;
    end else begin
      if (event_if.valid && event_if.ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("event kind %0d slot %0d with no event predicted",
                                    event_if.event_kind, event_if.button_slot));
        end else begin
          want = pending_events.pop_front();
          if (event_if.event_kind !== want.kind)
            report_mismatch($sformatf("event_kind got %0d want %0d (slot %0d)",
                                      event_if.event_kind, want.kind, want.slot));
          if (event_if.button_slot !== want.slot)
            report_mismatch($sformatf("button_slot got %0d want %0d",
                                      event_if.button_slot, want.slot));
          if (event_if.last_event !== want.last)
            report_mismatch($sformatf("last_event got %0b want %0b (slot %0d)",
                                      event_if.last_event, want.last, want.slot));
        end
      end
      if (choke_left != 0)
        event_if.ready <= 1'b0;
      else if (no_idle)
        event_if.ready <= 1'b1;
      else
        event_if.ready <= ($urandom_range(0, 99) >= 31);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL button_press_hold_event_generator");
      $finish;
    end
  end

  // register write request, applied to the predictor when taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      CFG_DEBOUNCE: cfg_debounce = val;
      CFG_HOLD:     cfg_hold     = val;
      CFG_REPEAT:   cfg_repeat   = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hld,
                           input logic [CFG_W-1:0] rep);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_HOLD, hld);
    write_reg(CFG_REPEAT, rep);
  endtask

  // wait until every tick is taken and every event seen, then let the block settle
  task automatic drain_ticks();
    while (pending_ticks.size() != 0 || tick_if.valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_tick(input logic [TIME_W-1:0] now, input logic [LEVEL_W-1:0] lv);
    pending_ticks.push_back('{now_ms: now, low_levels: lv});
  endtask

  // time step aimed near the configured thresholds, with some wide jumps
  function automatic logic [TIME_W-1:0] pick_delta();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'd0;
      1, 2, 3: return $urandom_range(1, 8);
      4:       return {16'd0, cfg_debounce} + $urandom_range(0, 2) - 32'd1;
      5:       return {16'd0, cfg_hold} + $urandom_range(0, 2) - 32'd1;
      6:       return {16'd0, cfg_repeat} + $urandom_range(0, 2) - 32'd1;
      7:       return $urandom_range(0, 2 * cfg_hold + 2);
      8:       return $urandom;
      default: return 32'd1;
    endcase
  endfunction

  // mostly single-button edges so presses, holds and releases follow through
  task automatic add_random_ticks(input int n);
    int r;
    repeat (n) begin
      clock_ms = clock_ms + pick_delta();
      r = $urandom_range(0, 99);
      if (r < 60)
        levels[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
      else if (r < 75)
        levels ^= LEVEL_W'($urandom_range(0, 255));
      else if (r >= 95)
        levels = LEVEL_W'($urandom_range(0, 255));
      add_tick(clock_ms, levels);
    end
  endtask

  initial begin
    tick_if.valid      = 1'b0;
    tick_if.now_ms     = '0;
    tick_if.low_levels = '0;
    event_if.ready     = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_DEBOUNCE;
    cfg_if.data        = '0;
    no_idle            = 1'b0;
    choke_go           = 1'b0;
    cfg_debounce       = DEBOUNCE_RST;
    cfg_hold           = HOLD_RST;
    cfg_repeat         = REPEAT_RST;
    for (int i = 0; i < N_BUTTONS; i++) begin
      btn_down[i]   = 1'b0;
      btn_held[i]   = 1'b0;
      down_since[i] = '0;
      edge_at[i]    = '0;
      repeat_at[i]  = '0;
    end
    clock_ms = '0;
    levels   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings
    add_tick(32'd0, 8'h00);              // quiet tick
    add_tick(32'd51, 8'hFF);             // every button pressed
    add_tick(32'd100, 8'hFF);            // still short of hold
    add_tick(32'd552, 8'hFF);            // hold once and hold on every button
    add_tick(32'd651, 8'hFF);            // one short of the repeat interval
    add_tick(32'd652, 8'hFF);            // repeat on every button
    add_tick(32'd653, 8'h0F);            // release after hold on upper half
    add_tick(32'd700, 8'h00);            // release after hold on lower half
    add_tick(32'd720, 8'h01);            // bounce rejected
    add_tick(32'd750, 8'h01);            // exactly at debounce, still rejected
    add_tick(32'd751, 8'h01);            // press
    add_tick(32'd760, 8'h00);            // click
    add_tick(32'hFFFF_FFF0, 8'h80);      // press just before the time wraps
    add_tick(32'h0000_0010, 8'h80);      // across the wrap, short of hold
    add_tick(32'h0000_0200, 8'h80);      // hold measured across the wrap
    add_tick(32'h0000_0300, 8'h00);      // release after hold
    add_tick(32'hFFFF_FFFF, 8'hAA);
    add_tick(32'hFFFF_FFFF, 8'h55);
    drain_ticks();

    // directed: all thresholds zero
    write_all('0, '0, '0);
    add_tick(32'd1000, 8'hFF);
    add_tick(32'd1000, 8'hFF);
    add_tick(32'd1001, 8'hFF);
    add_tick(32'd1001, 8'hFF);           // zero repeat interval fires every tick
    add_tick(32'd1001, 8'h00);
    drain_ticks();

    // directed: all thresholds at their maximum
    write_all(CFG_MAX, CFG_MAX, CFG_MAX);
    add_tick(32'd1002, 8'hFF);
    add_tick(32'd66537, 8'hFF);
    add_tick(32'd132073, 8'hFF);
    drain_ticks();

    // random: small thresholds, no idling on either side
    clock_ms = 32'd200000;
    levels   = 8'hFF;
    write_all(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 60)),
              CFG_W'($urandom_range(0, 30)));
    no_idle <= 1'b1;
    add_random_ticks(120);
    drain_ticks();
    no_idle <= 1'b0;

    // random: reset settings written back
    write_all(DEBOUNCE_RST, HOLD_RST, REPEAT_RST);
    add_random_ticks(110);
    drain_ticks();

    // random: receiver held off while ticks keep coming
    write_all(CFG_W'($urandom_range(0, 100)), CFG_W'($urandom_range(0, 300)),
              CFG_W'($urandom_range(1, 80)));
    choke_go <= 1'b1;
    add_random_ticks(90);
    drain_ticks();

    // random: zero thresholds, plus a write to the unused index
    write_all('0, '0, '0);
    write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 65535)));
    add_random_ticks(70);
    drain_ticks();

    // random: maximum thresholds
    write_all(CFG_MAX, CFG_MAX, CFG_MAX);
    add_random_ticks(70);
    drain_ticks();

    if (fail_count == 0)
      $display("PASS button_press_hold_event_generator");
    else
      $display("FAIL button_press_hold_event_generator");
    $finish;
  end

endmodule
